### rtl/core/dotq_pkg.sv
// dotq_pkg: shared constants, types and helpers of the deadline ordered timer queue
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int HANDLE_W    = 4;
  localparam int TIME_W      = 32;
  localparam int TAG_W       = 16;
  localparam int LEAD_W      = 16;
  // wide enough for deadline - now - lead without overflow
  localparam int DIFF_W      = TIME_W + 3;

  localparam logic [TIME_W-1:0] END_OF_TIME = 32'h7fff_ffff;
  localparam logic [LEAD_W-1:0] LEAD_RESET  = 16'd156;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_POLL    = 2'd2;
  localparam logic [1:0] ACT_PEEK    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // update request from the sequencer to the ordered store
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [IDX_W-1:0]         pos;
    logic signed [TIME_W-1:0] dl;
    logic [TAG_W-1:0]         tag;
  } st_cmd_t;

  // store status seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic [QUEUE_DEPTH-1:0]   busy;
    logic                     full;
    logic [IDX_W-1:0]         free_slot;
    logic signed [TIME_W-1:0] pos_dl;
    logic [IDX_W-1:0]         pos_slot;
    logic signed [TIME_W-1:0] head_dl;
    logic [TAG_W-1:0]         head_tag;
  } st_info_t;

  // saturate a wide difference to the signed 32-bit range
  function automatic logic [TIME_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic all_same;
    all_same = (&v[DIFF_W-1:TIME_W-1]) | ~(|v[DIFF_W-1:TIME_W-1]);
    if (all_same) begin
      sat32 = v[TIME_W-1:0];
    end else if (v[DIFF_W-1]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/dotq_alu.sv
// dotq_alu: the one shared subtractor of the queue, with sign flags
// depends on dotq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dotq_alu import dotq_pkg::*; (
  input  logic signed [DIFF_W-1:0] a_i,
  input  logic signed [DIFF_W-1:0] b_i,
  output logic signed [DIFF_W-1:0] diff_o,
  output logic                     gt_zero_o,
  output logic                     neg_o
);

  assign diff_o    = a_i - b_i;
  assign neg_o     = diff_o[DIFF_W-1];
  assign gt_zero_o = ~diff_o[DIFF_W-1] & (|diff_o);

endmodule

`default_nettype wire

### rtl/core/dotq_store.sv
// dotq_store: deadline ordered entry list with slot busy bits and pending count
// depends on dotq_pkg; driven by the sequencer in the top level
`timescale 1ns / 1ps
`default_nettype none

module dotq_store import dotq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  st_cmd_t  cmd_i,
  output st_info_t info_o
);

  logic signed [TIME_W-1:0] ord_dl_q   [QUEUE_DEPTH];
  logic [TAG_W-1:0]         ord_tag_q  [QUEUE_DEPTH];
  logic [IDX_W-1:0]         ord_slot_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   busy_q, busy_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         free_slot;
  logic                     has_free;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_slot = IDX_W'(i);
        has_free  = 1'b1;
      end
    end
  end

  // positions shift up on insert and down on remove
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_ent
    localparam int PREV = (g > 0) ? g - 1 : 0;
    localparam int NEXT = (g < QUEUE_DEPTH - 1) ? g + 1 : g;
    always_ff @(posedge clk_i) begin
      if (cmd_i.ins && (IDX_W'(g) == cmd_i.pos)) begin
        ord_dl_q[g]   <= cmd_i.dl;
        ord_tag_q[g]  <= cmd_i.tag;
        ord_slot_q[g] <= free_slot;
      end else if (cmd_i.ins && (IDX_W'(g) > cmd_i.pos)) begin
        ord_dl_q[g]   <= ord_dl_q[PREV];
        ord_tag_q[g]  <= ord_tag_q[PREV];
        ord_slot_q[g] <= ord_slot_q[PREV];
      end else if (cmd_i.rem && (IDX_W'(g) >= cmd_i.pos)) begin
        ord_dl_q[g]   <= ord_dl_q[NEXT];
        ord_tag_q[g]  <= ord_tag_q[NEXT];
        ord_slot_q[g] <= ord_slot_q[NEXT];
      end
    end
  end

  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (cmd_i.ins) begin
      busy_d[free_slot] = 1'b1;
      count_d           = count_q + CNT_W'(1);
    end else if (cmd_i.rem) begin
      busy_d[ord_slot_q[cmd_i.pos]] = 1'b0;
      count_d                       = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  assign info_o.count     = count_q;
  assign info_o.busy      = busy_q;
  assign info_o.full      = (count_q == CNT_W'(QUEUE_DEPTH)) | ~has_free;
  assign info_o.free_slot = free_slot;
  assign info_o.pos_dl    = ord_dl_q[cmd_i.pos];
  assign info_o.pos_slot  = ord_slot_q[cmd_i.pos];
  assign info_o.head_dl   = ord_dl_q[0];
  assign info_o.head_tag  = ord_tag_q[0];

endmodule

`default_nettype wire

### rtl/core/deadline_ordered_timer_queue_top.sv
// deadline_ordered_timer_queue_top: sequencer, result register and config register
// depends on dotq_pkg, dotq_alu and dotq_store
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer event queue holding up to 16 events (deadline, tag), kept in
// deadline order, with a new event placed ahead of equal deadlines. One item
// carries an action: enqueue (returns the slot handle, or full status),
// cancel by handle (or not-found status), poll (fires the head event when it
// is due within lead_window and then reports the wait to the new head less
// the window, clamped at zero, else the wait to the head) or peek (head
// deadline minus current time). An empty queue reports a wait of 0x7fffffff.
// Items are taken one at a time: in_stall_o stays high from acceptance until
// the result has been moved into the output register, which may still be
// waiting to be taken. Enqueue and cancel walk the order list one position
// per cycle; poll subtracts current time from the head deadline, then the
// window, and repeats this for the new head when it fires and events remain;
// peek subtracts once, all differences going through one shared 35-bit
// subtractor. Poll or peek of an empty queue, enqueue into a full one and
// cancel of an unknown handle go straight to the result. Any item takes
// longer while a result waits in a stalled output register. lead_window may
// be written through cfg_we_i only while the block is idle.

module deadline_ordered_timer_queue_top import dotq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [LEAD_W-1:0]        cfg_wdata_i,
  // input item
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [TIME_W-1:0] deadline_i,
  input  logic [TAG_W-1:0]         event_tag_i,
  input  logic [HANDLE_W-1:0]      cancel_handle_i,
  input  logic signed [TIME_W-1:0] current_time_i,
  // result item
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [HANDLE_W-1:0]      slot_handle_o,
  output logic                     fired_o,
  output logic [TAG_W-1:0]         fired_tag_o,
  output logic signed [TIME_W-1:0] wait_time_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ENQ_SCAN  = 4'd1;
  localparam logic [3:0] S_CAN_SCAN  = 4'd2;
  localparam logic [3:0] S_POLL_DIFF = 4'd3;
  localparam logic [3:0] S_POLL_CHK  = 4'd4;
  localparam logic [3:0] S_NEXT_DIFF = 4'd5;
  localparam logic [3:0] S_NEXT_CHK  = 4'd6;
  localparam logic [3:0] S_PEEK_DIFF = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [LEAD_W-1:0]        lead_q;
  logic [CNT_W-1:0]         pos_q, pos_d;

  // latched item fields
  logic signed [TIME_W-1:0] dl_q, dl_d;
  logic [TAG_W-1:0]         tag_q, tag_d;
  logic [HANDLE_W-1:0]      handle_q, handle_d;
  logic signed [TIME_W-1:0] now_q, now_d;

  // partial difference between the two subtractor passes
  logic signed [DIFF_W-1:0] w_q, w_d;

  // result being built
  logic [1:0]               res_status_q, res_status_d;
  logic [HANDLE_W-1:0]      res_slot_q, res_slot_d;
  logic                     res_fired_q, res_fired_d;
  logic [TAG_W-1:0]         res_tag_q, res_tag_d;
  logic [TIME_W-1:0]        res_wait_q, res_wait_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               out_status_q;
  logic [HANDLE_W-1:0]      out_slot_q;
  logic                     out_fired_q;
  logic [TAG_W-1:0]         out_tag_q;
  logic [TIME_W-1:0]        out_wait_q;
  logic                     out_load;

  st_cmd_t                  cmd;
  st_info_t                 info;

  logic signed [DIFF_W-1:0] alu_a, alu_b, alu_diff;
  logic                     alu_gt, alu_neg;
  logic signed [DIFF_W-1:0] lead_ext;
  logic                     accept;
  logic                     handle_ok;

  dotq_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .info_o (info)
  );

  dotq_alu u_alu (
    .a_i       (alu_a),
    .b_i       (alu_b),
    .diff_o    (alu_diff),
    .gt_zero_o (alu_gt),
    .neg_o     (alu_neg)
  );

  assign accept    = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign lead_ext  = signed'({{(DIFF_W - LEAD_W){1'b0}}, lead_q});
  // handle must name an existing slot that is pending
  assign handle_ok = (32'(cancel_handle_i) < QUEUE_DEPTH) &&
                     info.busy[IDX_W'(cancel_handle_i)];
  assign out_load  = (state_q == S_DONE) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    dl_d         = dl_q;
    tag_d        = tag_q;
    handle_d     = handle_q;
    now_d        = now_q;
    w_d          = w_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_fired_d  = res_fired_q;
    res_tag_d    = res_tag_q;
    res_wait_d   = res_wait_q;
    cmd          = '0;
    cmd.pos      = pos_q[IDX_W-1:0];
    cmd.dl       = dl_q;
    cmd.tag      = tag_q;
    alu_a        = DIFF_W'(info.head_dl);
    alu_b        = DIFF_W'(now_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dl_d         = deadline_i;
          tag_d        = event_tag_i;
          handle_d     = cancel_handle_i;
          now_d        = current_time_i;
          pos_d        = '0;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_fired_d  = 1'b0;
          res_tag_d    = '0;
          res_wait_d   = '0;
          case (action_i)
            ACT_ENQUEUE: begin
              if (info.full) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_ENQ_SCAN;
              end
            end
            ACT_CANCEL: begin
              if (!handle_ok) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                state_d = S_CAN_SCAN;
              end
            end
            ACT_POLL: begin
              if (info.count == '0) begin
                res_wait_d = END_OF_TIME;
                state_d    = S_DONE;
              end else begin
                state_d = S_POLL_DIFF;
              end
            end
            default: begin
              if (info.count == '0) begin
                res_wait_d = END_OF_TIME;
                state_d    = S_DONE;
              end else begin
                state_d = S_PEEK_DIFF;
              end
            end
          endcase
        end
      end

      // walk until the new deadline is no later than the entry at pos, or the list ends
      S_ENQ_SCAN: begin
        alu_a = DIFF_W'(dl_q);
        alu_b = DIFF_W'(info.pos_dl);
        if ((pos_q == info.count) || !alu_gt) begin
          cmd.ins    = 1'b1;
          res_slot_d = HANDLE_W'(info.free_slot);
          state_d    = S_DONE;
        end else begin
          pos_d = pos_q + CNT_W'(1);
        end
      end

      // the slot is pending, so it is found before the end of the list
      S_CAN_SCAN: begin
        if (info.pos_slot == IDX_W'(handle_q)) begin
          cmd.rem = 1'b1;
          state_d = S_DONE;
        end else begin
          pos_d = pos_q + CNT_W'(1);
        end
      end

      S_POLL_DIFF: begin
        w_d     = alu_diff;
        state_d = S_POLL_CHK;
      end

      S_POLL_CHK: begin
        alu_a = w_q;
        alu_b = lead_ext;
        if (alu_gt) begin
          // not yet due
          res_wait_d = sat32(w_q);
          state_d    = S_DONE;
        end else begin
          cmd.rem     = 1'b1;
          cmd.pos     = '0;
          res_fired_d = 1'b1;
          res_tag_d   = info.head_tag;
          if (info.count == CNT_W'(1)) begin
            res_wait_d = END_OF_TIME;
            state_d    = S_DONE;
          end else begin
            state_d = S_NEXT_DIFF;
          end
        end
      end

      S_NEXT_DIFF: begin
        w_d     = alu_diff;
        state_d = S_NEXT_CHK;
      end

      // wait to the new head less the window, clamped at zero
      S_NEXT_CHK: begin
        alu_a      = w_q;
        alu_b      = lead_ext;
        res_wait_d = alu_neg ? '0 : sat32(alu_diff);
        state_d    = S_DONE;
      end

      S_PEEK_DIFF: begin
        res_wait_d = sat32(alu_diff);
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lead_q      <= LEAD_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lead_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    dl_q         <= dl_d;
    tag_q        <= tag_d;
    handle_q     <= handle_d;
    now_q        <= now_d;
    w_q          <= w_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_fired_q  <= res_fired_d;
    res_tag_q    <= res_tag_d;
    res_wait_q   <= res_wait_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_fired_q  <= res_fired_q;
      out_tag_q    <= res_tag_q;
      out_wait_q   <= res_wait_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_handle_o = out_slot_q;
  assign fired_o       = out_fired_q;
  assign fired_tag_o   = out_tag_q;
  assign wait_time_o   = signed'(out_wait_q);

endmodule

`default_nettype wire
